// File: design/wpf_pkg.sv
// Shared types and constants of the waypoint path follower.
`default_nettype none
package wpf_pkg;

    localparam int unsigned OPW = 34;
    localparam int unsigned PW  = 68;
    localparam logic [33:0] BUDGET_MAX = 34'h3_FFFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_SETPOS = 2'd3
    } t_func;

    typedef enum logic [0:0] {
        CFG_SPEED       = 1'b0,
        CFG_STOP_RADIUS = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_func              func;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic        [31:0] delta_time;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [8:0]  next_index;
        logic               arrived;
        logic               full_flag;
    } t_out_rsp;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_SQRT = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic          done;
        logic [PW-1:0] result;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUD_GO,
        S_BUD_W,
        S_LOOP,
        S_RD,
        S_SQ_GO,
        S_SQ_W,
        S_CMP,
        S_SQRT_GO,
        S_SQRT_W,
        S_MV_GO,
        S_MV_W,
        S_DV_W,
        S_FIN,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// File: design/waypoint_path_follower.sv
// Top level: request handling, tick sequencer and output register of the path follower.
`default_nettype none
// Clear, append and set-position requests go straight to the output state. A
// tick first works out the travel budget, then handles each waypoint: it is
// skipped when it lies within the stop radius, else the point moves toward
// it; one serial arithmetic unit (multiply, divide, square root)
// does all the work, so the tick time grows with the number of
// waypoints it passes. One request is in work at a time; a finished result waits
// in the output register while the next request is taken.
module waypoint_path_follower #(
    parameter int unsigned MAX_POINTS = 256,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wpf_pkg::t_in_req       i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output wpf_pkg::t_out_rsp      o_out_rsp,
    input  wire logic              i_cfg_we,
    input  wpf_pkg::t_cfg_reg      i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data
);
    import wpf_pkg::*;

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam logic [34:0] SNAP_TOL =
        35'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r;
    endfunction

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_target, n_target;
    logic               r_done, n_done;
    logic               r_full, n_full;
    logic [31:0]        r_speed, n_speed;
    logic [31:0]        r_radius, n_radius;
    logic [31:0]        r_dt, n_dt;
    logic signed [31:0] r_cur [3];
    logic signed [31:0] n_cur [3];
    logic signed [31:0] r_wp [3];
    logic signed [31:0] n_wp [3];
    logic signed [32:0] r_d [3];
    logic signed [32:0] n_d [3];
    logic [65:0]        r_s, n_s;
    logic [63:0]        r_r2, n_r2;
    logic [33:0]        r_budget, n_budget;
    logic [32:0]        r_dist, n_dist;
    logic [33:0]        r_step, n_step;
    logic [1:0]         r_axis, n_axis;
    logic               r_ovalid, n_ovalid;
    t_out_rsp           r_out, n_out;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;
    logic [PW-1:0]      alu_opa;
    logic [OPW-1:0]     alu_opb;

    logic               mem_we;
    t_point             mem_wdata;
    t_point             mem_rdata;

    logic [63:0]        bud_shift;
    logic [32:0]        cur_mag;
    logic [32:0]        move_q;
    logic signed [33:0] move_sum;
    logic [31:0]        tgt_wide;

    assign mem_wdata.x = i_in_req.point_x;
    assign mem_wdata.y = i_in_req.point_y;
    assign mem_wdata.z = i_in_req.point_z;
    assign mem_we = (r_state == S_IDLE) && i_in_valid && (i_in_req.func == FUNC_APPEND)
                    && (r_count < CW'(MAX_POINTS));

    wpf_path_mem #(
        .MAX_POINTS(MAX_POINTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (r_target[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    wpf_serial_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_opa   (alu_opa),
        .i_opb   (alu_opb),
        .o_rsp   (alu_rsp)
    );

    assign bud_shift = alu_rsp.result[63:0] >> FRAC_BITS;
    assign cur_mag   = mag33(r_d[r_axis]);
    assign move_q    = alu_rsp.result[32:0];
    assign move_sum  = r_d[r_axis][32]
                     ? 34'(signed'(r_cur[r_axis])) - signed'({1'b0, move_q})
                     : 34'(signed'(r_cur[r_axis])) + signed'({1'b0, move_q});
    assign tgt_wide  = 32'(r_target);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_rsp   = r_out;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_target = r_target;
        n_done   = r_done;
        n_full   = r_full;
        n_speed  = r_speed;
        n_radius = r_radius;
        n_dt     = r_dt;
        n_cur    = r_cur;
        n_wp     = r_wp;
        n_d      = r_d;
        n_s      = r_s;
        n_r2     = r_r2;
        n_budget = r_budget;
        n_dist   = r_dist;
        n_step   = r_step;
        n_axis   = r_axis;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_MUL;
        alu_opa  = '0;
        alu_opb  = '0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPEED:       n_speed  = i_cfg_data;
                CFG_STOP_RADIUS: n_radius = i_cfg_data;
                default:         n_speed  = r_speed;
            endcase
        end

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_full  = 1'b0;
                    n_state = S_OUT;
                    case (i_in_req.func)
                        FUNC_CLEAR: begin
                            n_count  = '0;
                            n_target = '0;
                            n_done   = 1'b1;
                        end
                        FUNC_APPEND: begin
                            if (r_count >= CW'(MAX_POINTS)) begin
                                n_full = 1'b1;
                            end else begin
                                n_count = r_count + CW'(1);
                                n_done  = 1'b0;
                            end
                        end
                        FUNC_TICK: begin
                            n_dt = i_in_req.delta_time;
                            if (!r_done) begin
                                if (r_target >= r_count) begin
                                    n_done = 1'b1;
                                end else begin
                                    n_state = S_BUD_GO;
                                end
                            end
                        end
                        FUNC_SETPOS: begin
                            n_cur[0] = i_in_req.point_x;
                            n_cur[1] = i_in_req.point_y;
                            n_cur[2] = i_in_req.point_z;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_BUD_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_opa       = PW'(r_speed);
                alu_opb       = OPW'(r_dt);
                n_state       = S_BUD_W;
            end
            S_BUD_W: begin
                if (alu_rsp.done) begin
                    n_budget = (|bud_shift[63:34]) ? BUDGET_MAX : bud_shift[33:0];
                    n_state  = S_LOOP;
                end
            end
            S_LOOP: begin
                if (r_target >= r_count) begin
                    n_done  = 1'b1;
                    n_state = S_OUT;
                end else if (r_budget == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_wp[0] = mem_rdata.x;
                n_wp[1] = mem_rdata.y;
                n_wp[2] = mem_rdata.z;
                n_d[0]  = 33'(signed'(mem_rdata.x)) - 33'(signed'(r_cur[0]));
                n_d[1]  = 33'(signed'(mem_rdata.y)) - 33'(signed'(r_cur[1]));
                n_d[2]  = 33'(signed'(mem_rdata.z)) - 33'(signed'(r_cur[2]));
                n_s     = '0;
                n_axis  = 2'd0;
                n_state = S_SQ_GO;
            end
            S_SQ_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                if (r_axis == 2'd3) begin
                    alu_opa = PW'(r_radius);
                    alu_opb = OPW'(r_radius);
                end else begin
                    alu_opa = PW'(cur_mag);
                    alu_opb = OPW'(cur_mag);
                end
                n_state = S_SQ_W;
            end
            S_SQ_W: begin
                if (alu_rsp.done) begin
                    if (r_axis == 2'd3) begin
                        n_r2    = alu_rsp.result[63:0];
                        n_state = S_CMP;
                    end else begin
                        n_s     = r_s + alu_rsp.result[65:0];
                        n_state = S_SQ_GO;
                    end
                    n_axis = r_axis + 2'd1;
                end
            end
            S_CMP: begin
                if (r_s <= 66'(r_r2)) begin
                    n_cur    = r_wp;
                    n_target = r_target + CW'(1);
                    n_state  = S_LOOP;
                end else begin
                    n_state = S_SQRT_GO;
                end
            end
            S_SQRT_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_SQRT;
                alu_opa       = PW'(r_s);
                n_state       = S_SQRT_W;
            end
            S_SQRT_W: begin
                if (alu_rsp.done) begin
                    n_dist  = alu_rsp.result[32:0];
                    n_step  = (r_budget < 34'(alu_rsp.result[32:0]))
                            ? r_budget : 34'(alu_rsp.result[32:0]);
                    n_axis  = 2'd0;
                    n_state = S_MV_GO;
                end
            end
            S_MV_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_opa       = PW'(cur_mag);
                alu_opb       = r_step;
                n_state       = S_MV_W;
            end
            S_MV_W: begin
                if (alu_rsp.done) begin
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_DIV;
                    alu_opa       = alu_rsp.result;
                    alu_opb       = OPW'(r_dist);
                    n_state       = S_DV_W;
                end
            end
            S_DV_W: begin
                if (alu_rsp.done) begin
                    if (move_sum[33:31] == 3'b000 || move_sum[33:31] == 3'b111) begin
                        n_cur[r_axis] = move_sum[31:0];
                    end else if (move_sum[33]) begin
                        n_cur[r_axis] = 32'sh8000_0000;
                    end else begin
                        n_cur[r_axis] = 32'sh7FFF_FFFF;
                    end
                    n_axis  = r_axis + 2'd1;
                    n_state = (r_axis == 2'd2) ? S_FIN : S_MV_GO;
                end
            end
            S_FIN: begin
                n_budget = r_budget - r_step;
                if ((35'(r_step) + SNAP_TOL) >= 35'(r_dist)) begin
                    n_cur    = r_wp;
                    n_target = r_target + CW'(1);
                end
                n_state = S_LOOP;
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out.pos_x      = r_cur[0];
                    n_out.pos_y      = r_cur[1];
                    n_out.pos_z      = r_cur[2];
                    n_out.next_index = tgt_wide[8:0];
                    n_out.arrived    = r_done;
                    n_out.full_flag  = r_full;
                    n_ovalid         = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_target <= '0;
            r_done   <= 1'b1;
            r_full   <= 1'b0;
            r_speed  <= 32'd65536;
            r_radius <= '0;
            r_ovalid <= 1'b0;
            r_cur[0] <= '0;
            r_cur[1] <= '0;
            r_cur[2] <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_target <= n_target;
            r_done   <= n_done;
            r_full   <= n_full;
            r_speed  <= n_speed;
            r_radius <= n_radius;
            r_ovalid <= n_ovalid;
            r_cur    <= n_cur;
        end
        r_dt     <= n_dt;
        r_wp     <= n_wp;
        r_d      <= n_d;
        r_s      <= n_s;
        r_r2     <= n_r2;
        r_budget <= n_budget;
        r_dist   <= n_dist;
        r_step   <= n_step;
        r_axis   <= n_axis;
        r_out    <= n_out;
    end

endmodule
`default_nettype wire

// File: design/wpf_path_mem.sv
// Waypoint memory: one write port, one registered read port.
`default_nettype none
module wpf_path_mem #(
    parameter int unsigned MAX_POINTS = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_waddr,
    input  wpf_pkg::t_point                    i_wdata,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_raddr,
    output wpf_pkg::t_point                    o_rdata
);
    import wpf_pkg::*;

    t_point r_mem [MAX_POINTS];
    t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: design/wpf_serial_alu.sv
// Shared serial unit: shift-add multiply, restoring divide, digit-by-digit square root.
`default_nettype none
module wpf_serial_alu (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wpf_pkg::t_alu_req           i_req,
    input  wire logic [wpf_pkg::PW-1:0] i_opa,
    input  wire logic [wpf_pkg::OPW-1:0] i_opb,
    output wpf_pkg::t_alu_rsp           o_rsp
);
    import wpf_pkg::*;

    logic [PW-1:0]  r_acc;
    logic [OPW-1:0] r_mcand;
    logic [OPW-1:0] r_opb;
    logic [33:0]    r_rem;
    logic [32:0]    r_root;
    logic [6:0]     r_cnt;
    logic           r_busy;
    logic           r_done;
    t_alu_op        r_op;

    logic [OPW:0]   mul_sum;
    logic [34:0]    div_trial;
    logic           div_ge;
    logic [35:0]    sq_rem;
    logic [35:0]    sq_trial;
    logic           sq_ge;

    assign mul_sum   = {1'b0, r_acc[PW-1:OPW]} + (r_opb[0] ? {1'b0, r_mcand} : '0);
    assign div_trial = {r_rem, r_acc[PW-1]};
    assign div_ge    = div_trial >= {1'b0, r_opb};
    assign sq_rem    = {r_rem, r_acc[65:64]};
    assign sq_trial  = {1'b0, r_root, 2'b01};
    assign sq_ge     = sq_rem >= sq_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ALU_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_rem  <= '0;
                r_root <= '0;
                r_opb  <= i_opb;
                case (i_req.op)
                    ALU_MUL: begin
                        r_acc   <= '0;
                        r_mcand <= i_opa[OPW-1:0];
                        r_cnt   <= 7'(OPW);
                    end
                    ALU_DIV: begin
                        r_acc <= i_opa;
                        r_cnt <= 7'(PW);
                    end
                    ALU_SQRT: begin
                        r_acc <= i_opa;
                        r_cnt <= 7'd33;
                    end
                    default: begin
                        r_acc <= '0;
                        r_cnt <= 7'd1;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    ALU_MUL: begin
                        r_acc <= {mul_sum, r_acc[OPW-1:1]};
                        r_opb <= r_opb >> 1;
                    end
                    ALU_DIV: begin
                        r_rem <= div_ge ? 34'(div_trial - {1'b0, r_opb}) : div_trial[33:0];
                        r_acc <= {r_acc[PW-2:0], div_ge};
                    end
                    ALU_SQRT: begin
                        r_rem  <= sq_ge ? 34'(sq_rem - sq_trial) : sq_rem[33:0];
                        r_root <= {r_root[31:0], sq_ge};
                        r_acc  <= {r_acc[PW-3:0], 2'b00};
                    end
                    default: begin
                        r_acc <= r_acc;
                    end
                endcase
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.done   = r_done;
        o_rsp.result = (r_op == ALU_SQRT) ? PW'(r_root) : r_acc;
    end

endmodule
`default_nettype wire
